>>> hw/rtl/tsc_pkg.sv
// Package for the tagged script cache: sizes, codes and the item types.
// Used by the channel interfaces and by every module of the cache.
package tsc_pkg;

	localparam int ENTRIES     = 8;
	localparam int BLOCK_BYTES = 64;

	localparam int SLOT_W     = $clog2(ENTRIES);
	localparam int LEN_W      = $clog2(BLOCK_BYTES + 1);
	localparam int IDX_W      = 6;
	localparam int CMP_W      = (LEN_W > IDX_W) ? LEN_W : IDX_W;
	localparam int TAG_W      = 8;
	localparam int STAMP_W    = 32;
	localparam int BYTE_W     = 8;
	localparam int OUT_SLOT_W = 3;
	localparam int MEM_DEPTH  = ENTRIES * BLOCK_BYTES;
	localparam int MEM_AW     = $clog2(MEM_DEPTH);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		JOB_START,
		JOB_FILL,
		JOB_LOOKUP
	} job_kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCAN,
		B_START,
		B_FILL,
		B_MATCH,
		B_READ
	} back_state_t;

	typedef struct packed {
		op_t                op;
		logic [TAG_W-1:0]   profile_index;
		logic [TAG_W-1:0]   key_index;
		logic               pressed;
		logic [STAMP_W-1:0] stamp;
		logic [IDX_W-1:0]   byte_index;
		logic [BYTE_W-1:0]  byte_value;
	} tsc_item_t;

	typedef struct packed {
		job_kind_t kind;
		tsc_item_t item;
	} tsc_job_t;

	typedef struct packed {
		logic                  found;
		logic [BYTE_W-1:0]     read_byte;
		logic [OUT_SLOT_W-1:0] slot;
	} tsc_result_t;

	function automatic job_kind_t classify(input tsc_item_t it);
		job_kind_t k;
		if (it.op == OP_LOOKUP) begin
			k = JOB_LOOKUP;
		end else if (it.byte_index == '0) begin
			k = JOB_START;
		end else begin
			k = JOB_FILL;
		end
		return k;
	endfunction

	function automatic logic [MEM_AW-1:0] mem_addr(input logic [SLOT_W-1:0] s,
		input logic [IDX_W-1:0] idx);
		return MEM_AW'(int'(s) * BLOCK_BYTES + int'(idx));
	endfunction

endpackage

>>> hw/rtl/tsc_req_if.sv
// Request channel of the tagged script cache: valid, ready and one input item.
// Depends on tsc_pkg for the field widths.
interface tsc_req_if import tsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [TAG_W-1:0]   profile_index;
	logic [TAG_W-1:0]   key_index;
	logic               pressed;
	logic [STAMP_W-1:0] stamp;
	logic [IDX_W-1:0]   byte_index;
	logic [BYTE_W-1:0]  byte_value;

	modport source(output valid, op, profile_index, key_index, pressed, stamp,
		byte_index, byte_value, input ready);
	modport sink(input valid, op, profile_index, key_index, pressed, stamp,
		byte_index, byte_value, output ready);
endinterface

>>> hw/rtl/tsc_rsp_if.sv
// Response channel of the tagged script cache: valid, ready and one result item.
// Depends on tsc_pkg for the field widths.
interface tsc_rsp_if import tsc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [BYTE_W-1:0]     read_byte;
	logic [OUT_SLOT_W-1:0] slot;

	modport source(output valid, found, read_byte, slot, input ready);
	modport sink(input valid, found, read_byte, slot, output ready);
endinterface

>>> hw/rtl/tsc_front.sv
// Front stage of the tagged script cache: accepts items and classifies them.
// Depends on tsc_pkg and tsc_req_if.
module tsc_front import tsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tsc_req_if.sink   req,
	output tsc_job_t  job,
	output logic      job_valid,
	input  logic      job_ready
);

	logic      vld_s1;
	tsc_job_t  job_s1;
	tsc_item_t item_c;
	logic      take;

	always_comb begin
		item_c.op            = op_t'(req.op);
		item_c.profile_index = req.profile_index;
		item_c.key_index     = req.key_index;
		item_c.pressed       = req.pressed;
		item_c.stamp         = req.stamp;
		item_c.byte_index    = req.byte_index;
		item_c.byte_value    = req.byte_value;
	end

	assign req.ready = !vld_s1 || job_ready;
	assign take      = req.valid && req.ready;
	assign job       = job_s1;
	assign job_valid = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (job_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_s1.kind <= classify(item_c);
			job_s1.item <= item_c;
		end
	end

endmodule

>>> hw/rtl/tsc_queue.sv
// Short job queue between the front and back of the tagged script cache.
// Depends on tsc_pkg for the job type and depth.
module tsc_queue import tsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tsc_job_t push_job,
	input  logic     push_valid,
	output logic     push_ready,
	output tsc_job_t pop_job,
	output logic     pop_valid,
	input  logic     pop_ready
);

	tsc_job_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> hw/rtl/tsc_back.sv
// Back part of the tagged script cache: tag store, victim scan, block memory.
// Depends on tsc_pkg and tsc_rsp_if; takes jobs from tsc_queue.
module tsc_back import tsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tsc_job_t job,
	input  logic     job_valid,
	output logic     job_ready,
	tsc_rsp_if.source rsp
);

	logic [TAG_W-1:0]   tag_prof_q  [ENTRIES];
	logic [TAG_W-1:0]   tag_key_q   [ENTRIES];
	logic               tag_press_q [ENTRIES];
	logic [STAMP_W-1:0] stamp_q     [ENTRIES];
	logic [LEN_W-1:0]   len_q       [ENTRIES];
	logic [SLOT_W-1:0]  fill_slot_q;

	logic [BYTE_W-1:0]  mem [MEM_DEPTH];

	back_state_t        state_q;
	back_state_t        state_d;
	tsc_job_t           cur_q;
	logic [SLOT_W-1:0]  scan_q;
	logic [STAMP_W-1:0] low_q;
	logic [SLOT_W-1:0]  best_q;
	logic [SLOT_W-1:0]  vic_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  mslot_q;
	logic               rd_ok_q;
	logic [BYTE_W-1:0]  rdata_q;
	tsc_result_t        res_q;
	logic               res_vld_q;

	logic [ENTRIES-1:0] hit_vec;
	logic               any_hit;
	logic [SLOT_W-1:0]  mslot_c;
	logic [SLOT_W-1:0]  len_idx;
	logic [LEN_W-1:0]   len_sel;
	logic [CMP_W-1:0]   idx_w;
	logic [CMP_W-1:0]   len_w;
	logic               idx_in_block;
	logic               fill_ok;
	logic               fill_grow;
	logic               rd_ok_c;
	logic [STAMP_W-1:0] scan_stamp;
	logic               scan_free;
	logic               scan_last;
	logic               scan_le;
	logic [SLOT_W-1:0]  scan_vic;
	logic               scan_done;
	logic               adv;
	logic               load_res;
	logic               mem_we;
	logic [MEM_AW-1:0]  wr_addr;
	logic [MEM_AW-1:0]  rd_addr;
	tsc_result_t        res_c;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i] = (stamp_q[i] != '0) &&
				(tag_prof_q[i] == cur_q.item.profile_index) &&
				(tag_key_q[i] == cur_q.item.key_index) &&
				(tag_press_q[i] == cur_q.item.pressed);
		end
		mslot_c = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				mslot_c = SLOT_W'(i);
			end
		end
		any_hit = |hit_vec;
	end

	assign len_idx      = (state_q == B_MATCH) ? mslot_c : fill_slot_q;
	assign len_sel      = len_q[len_idx];
	assign idx_w        = CMP_W'(cur_q.item.byte_index);
	assign len_w        = CMP_W'(len_sel);
	assign idx_in_block = idx_w < CMP_W'(BLOCK_BYTES);
	assign fill_ok      = idx_in_block && (idx_w <= len_w);
	assign fill_grow    = idx_w == len_w;
	assign rd_ok_c      = any_hit && idx_in_block && (idx_w < len_w);

	assign scan_stamp = stamp_q[scan_q];
	assign scan_free  = scan_stamp == '0;
	assign scan_last  = scan_q == SLOT_W'(ENTRIES - 1);
	assign scan_le    = scan_stamp <= low_q;
	assign scan_done  = scan_free || scan_last;
	assign scan_vic   = (scan_free || scan_le) ? scan_q : best_q;

	assign adv     = !res_vld_q || rsp.ready;
	assign wr_addr = (state_q == B_START) ? mem_addr(vic_q, '0) :
		mem_addr(fill_slot_q, cur_q.item.byte_index);
	assign rd_addr = mem_addr(mslot_c, cur_q.item.byte_index);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					unique case (job.kind)
						JOB_START:  state_d = B_SCAN;
						JOB_FILL:   state_d = B_FILL;
						JOB_LOOKUP: state_d = B_MATCH;
						default:    state_d = B_IDLE;
					endcase
				end
			end
			B_SCAN: begin
				if (scan_done) begin
					state_d = B_START;
				end
			end
			B_START, B_FILL, B_READ: begin
				if (adv) begin
					state_d = B_IDLE;
				end
			end
			B_MATCH: state_d = B_READ;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		job_ready = 1'b0;
		load_res  = 1'b0;
		mem_we    = 1'b0;
		res_c     = '0;
		unique case (state_q)
			B_IDLE: job_ready = 1'b1;
			B_START: begin
				load_res   = adv;
				mem_we     = adv;
				res_c.slot = OUT_SLOT_W'(vic_q);
			end
			B_FILL: begin
				load_res   = adv;
				mem_we     = adv && fill_ok;
				res_c.slot = OUT_SLOT_W'(fill_slot_q);
			end
			B_READ: begin
				load_res        = adv;
				res_c.found     = hit_q;
				res_c.read_byte = rd_ok_q ? rdata_q : '0;
				res_c.slot      = OUT_SLOT_W'(mslot_q);
			end
			B_SCAN, B_MATCH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_vld_q   <= 1'b0;
			fill_slot_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				tag_prof_q[i]  <= '0;
				tag_key_q[i]   <= '0;
				tag_press_q[i] <= 1'b0;
				stamp_q[i]     <= '0;
				len_q[i]       <= '0;
			end
		end else begin
			state_q <= state_d;
			if (load_res) begin
				res_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				res_vld_q <= 1'b0;
			end
			if (state_q == B_START && adv) begin
				tag_prof_q[vic_q]  <= cur_q.item.profile_index;
				tag_key_q[vic_q]   <= cur_q.item.key_index;
				tag_press_q[vic_q] <= cur_q.item.pressed;
				stamp_q[vic_q]     <= cur_q.item.stamp;
				len_q[vic_q]       <= LEN_W'(1);
				fill_slot_q        <= vic_q;
			end
			if (state_q == B_FILL && adv && fill_ok && fill_grow) begin
				len_q[fill_slot_q] <= len_sel + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && job_valid) begin
			cur_q  <= job;
			scan_q <= '0;
			low_q  <= '1;
			best_q <= '0;
		end
		if (state_q == B_SCAN) begin
			if (scan_done) begin
				vic_q <= scan_vic;
			end else begin
				scan_q <= scan_q + 1'b1;
				if (scan_le) begin
					low_q  <= scan_stamp;
					best_q <= scan_q;
				end
			end
		end
		if (state_q == B_MATCH) begin
			hit_q   <= any_hit;
			mslot_q <= mslot_c;
			rd_ok_q <= rd_ok_c;
		end
		if (load_res) begin
			res_q <= res_c;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= cur_q.item.byte_value;
		end
		if (state_q == B_MATCH) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rsp.valid     = res_vld_q;
	assign rsp.found     = res_q.found;
	assign rsp.read_byte = res_q.read_byte;
	assign rsp.slot      = res_q.slot;

	a_fill_len: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(len_q[fill_slot_q]) <= CMP_W'(BLOCK_BYTES))
		else $error("Fill slot length exceeds the block size.");

	a_hit_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ && hit_q) |-> (stamp_q[mslot_q] != '0))
		else $error("Lookup hit on a free entry.");

	a_take_job: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job_ready) |=> (state_q != B_IDLE))
		else $error("Job taken but back part stayed idle.");

	a_read_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |-> ($past(state_q) == B_MATCH || $past(state_q) == B_READ))
		else $error("Read state entered without a match cycle.");

endmodule

>>> hw/rtl/tagged_script_cache.sv
// Tagged script cache: fully associative, oldest-stamp replacement, one result per item.
// Input passes the front register and the two-item queue; then a fill add takes the fill
// state, a lookup a match and a registered block read, and an add at offset zero a victim
// scan, reading one stamp per cycle up to the first free or the last slot, and the start state.
// The back part takes one job at a time; front register and queue accept input until full.
// Asynchronous reset clears tags, stamps, lengths and the fill slot; block bytes are not cleared.
module tagged_script_cache import tsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tsc_req_if.sink   req,
	tsc_rsp_if.source rsp
);

	tsc_job_t front_job;
	logic     front_valid;
	logic     front_ready;
	tsc_job_t back_job;
	logic     back_valid;
	logic     back_ready;

	tsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	tsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (front_job),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_job    (back_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	tsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.rsp       (rsp)
	);

endmodule
